// ===== sv/dual_serial_gamepad_reader_assert.svh =====
// Assertion macros shared by the gamepad reader RTL.
// Expects signals named clock and reset in the including module's scope.
`ifndef DUAL_SERIAL_GAMEPAD_READER_ASSERT_SVH
`define DUAL_SERIAL_GAMEPAD_READER_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property check, off during reset
`define DSGR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("gamepad reader assertion failed");
// Antecedent in one cycle implies consequent in the next
`define DSGR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gamepad reader assertion failed");
`else
`define DSGR_ASSERT(label, prop)
`define DSGR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/dsgr_pkg.sv =====
// Shared types and constants for the dual serial gamepad reader.
// No dependencies; used by the interfaces, the register file and the scan engine.
package dsgr_pkg;

   // Fixed widths of the item fields and registers
   localparam int WORD_W = 16;
   localparam int CFG_W = 16;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Default number of buttons shifted per pad
   localparam int BUTTON_BITS_DEFAULT = 16;

   // Register reset values
   localparam logic [CFG_W-1:0] READ_GAP_RESET = CFG_W'(8);
   localparam logic [CFG_W-1:0] CLOCK_HALF_RESET = CFG_W'(2);

   // Register word index (byte address / 4)
   typedef enum logic {
      REG_READ_GAP   = 1'b0,
      REG_CLOCK_HALF = 1'b1
   } dsgr_reg_type;

   // Timing configuration handed from the register file to the scan engine
   typedef struct packed {
      logic [CFG_W-1:0] read_gap;
      logic [CFG_W-1:0] clock_half;
   } dsgr_cfg_type;

endpackage

// ===== sv/dsgr_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
// Depends on dsgr_pkg for the word width.
interface dsgr_req_if;
   logic valid;
   logic ready;
   logic enable;
   logic bit_p1;
   logic bit_p2;
   logic clear_p1;
   logic clear_p2;

   modport source (output valid, enable, bit_p1, bit_p2, clear_p1, clear_p2, input ready);
   modport sink (input valid, enable, bit_p1, bit_p2, clear_p1, clear_p2, output ready);
endinterface

interface dsgr_rsp_if;
   import dsgr_pkg::*;

   logic              valid;
   logic              ready;
   logic              latch_strobe;
   logic              clock_strobe;
   logic [WORD_W-1:0] held_p1;
   logic [WORD_W-1:0] held_p2;
   logic [WORD_W-1:0] presses_p1;
   logic [WORD_W-1:0] presses_p2;
   logic              scan_ready;

   modport source (output valid, latch_strobe, clock_strobe, held_p1, held_p2,
                   presses_p1, presses_p2, scan_ready, input ready);
   modport sink (input valid, latch_strobe, clock_strobe, held_p1, held_p2,
                 presses_p1, presses_p2, scan_ready, output ready);
endinterface

// ===== sv/dual_serial_gamepad_reader.sv =====
// Top level of the dual serial gamepad reader: register file plus scan engine.
// Depends on dsgr_pkg, dsgr_if, dsgr_csr and dsgr_scan.
//
// Each req item is one tick of a prescaled time base. The block takes one item
// every clock and returns exactly one rsp item per tick from an output
// register; req_chan.ready stays high unless that register is full and
// rsp_chan.ready is low. While enable is high the tick drives a shared two-pad
// scan of 2 + 2*BUTTON_BITS steps: a wait of read_gap+1 ticks, the latch pulse,
// then BUTTON_BITS clock pulses, each phase clock_half+1 ticks long. Bits are
// shifted in lowest first on each clock release; after the last one the held
// words update, newly pressed buttons OR into the press words and scan_ready
// sets. clear_p1/clear_p2 zero a press word after the result of that item.
// Registers sit at byte address 0 (read_gap) and 4 (clock_half) and take effect
// at the next reload of the tick counter.
module dual_serial_gamepad_reader #(
   parameter int BUTTON_BITS = dsgr_pkg::BUTTON_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   dsgr_req_if.sink                        req_chan,
   dsgr_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dsgr_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [dsgr_pkg::APB_DATA_W-1:0] pwdata,
   output logic [dsgr_pkg::APB_DATA_W-1:0] prdata,
   output logic                            pready
);
   import dsgr_pkg::*;

   dsgr_cfg_type cfg;

   dsgr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dsgr_scan #(
      .BUTTON_BITS (BUTTON_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sv/dsgr_csr.sv =====
// APB-style register file holding read_gap and clock_half.
// Depends on dsgr_pkg for register indexes, widths and reset values.
module dsgr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dsgr_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [dsgr_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [dsgr_pkg::APB_DATA_W-1:0]    prdata,
   output logic                               pready,
   output dsgr_pkg::dsgr_cfg_type             cfg
);
   import dsgr_pkg::*;

   logic [CFG_W-1:0] read_gap_ff, read_gap_in;
   logic [CFG_W-1:0] clock_half_ff, clock_half_in;
   dsgr_reg_type     reg_sel;
   logic             wr_en;

   assign pready = 1'b1;
   assign reg_sel = dsgr_reg_type'(paddr[2]);
   assign wr_en = psel && penable && pwrite && pready;

   // Write decode
   always_comb begin
      read_gap_in = read_gap_ff;
      clock_half_in = clock_half_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_READ_GAP:   read_gap_in = pwdata[CFG_W-1:0];
            REG_CLOCK_HALF: clock_half_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_gap_ff <= READ_GAP_RESET;
         clock_half_ff <= CLOCK_HALF_RESET;
      end else begin
         read_gap_ff <= read_gap_in;
         clock_half_ff <= clock_half_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_READ_GAP:   prdata = APB_DATA_W'(read_gap_ff);
         REG_CLOCK_HALF: prdata = APB_DATA_W'(clock_half_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.read_gap = read_gap_ff;
   assign cfg.clock_half = clock_half_ff;

endmodule

// ===== sv/dsgr_scan.sv =====
// Scan engine: step sequencer, shift words, held and press words, result register.
// Depends on dsgr_pkg, dsgr_if and the assertion macro header.
`include "dual_serial_gamepad_reader_assert.svh"

module dsgr_scan #(
   parameter int BUTTON_BITS = dsgr_pkg::BUTTON_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dsgr_pkg::dsgr_cfg_type cfg,
   dsgr_req_if.sink               req_chan,
   dsgr_rsp_if.source             rsp_chan
);
   import dsgr_pkg::*;

   localparam int STEP_COUNT = 2 + 2 * BUTTON_BITS;
   localparam int LAST_STEP = 1 + 2 * BUTTON_BITS;
   localparam int STEP_W = $clog2(STEP_COUNT);
   localparam int POS_W = $clog2(BUTTON_BITS);
   localparam logic [STEP_W-1:0] STEP_LATCH_OFF = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_FIRST_BIT = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LAST_STEP);

   // Sequencer and scan state
   logic [STEP_W-1:0]      phase_ff, phase_in;
   logic [CFG_W-1:0]       wait_ff, wait_in;
   logic [BUTTON_BITS-1:0] shift_p1_ff, shift_p1_in;
   logic [BUTTON_BITS-1:0] shift_p2_ff, shift_p2_in;
   logic [BUTTON_BITS-1:0] prev_p1_ff, prev_p1_in;
   logic [BUTTON_BITS-1:0] prev_p2_ff, prev_p2_in;
   logic [BUTTON_BITS-1:0] held_p1_ff, held_p1_in;
   logic [BUTTON_BITS-1:0] held_p2_ff, held_p2_in;
   logic [BUTTON_BITS-1:0] press_p1_ff, press_p1_in;
   logic [BUTTON_BITS-1:0] press_p2_ff, press_p2_in;
   logic [BUTTON_BITS-1:0] press_p1_scan, press_p2_scan;
   logic                   ready_flag_ff, ready_flag_in;
   logic                   enable_prev_ff;

   // Result register
   logic                   rsp_valid_ff;
   logic                   latch_ff, latch_in;
   logic                   clock_ff, clock_in;
   logic [WORD_W-1:0]      held_p1_out_ff, held_p2_out_ff;
   logic [WORD_W-1:0]      press_p1_out_ff, press_p2_out_ff;
   logic                   scan_ready_out_ff;

   logic                   accept;
   logic                   run_step;
   logic                   bit_step;
   logic [STEP_W-2:0]      pos_full;
   logic [POS_W-1:0]       pos;
   logic [BUTTON_BITS-1:0] bit_mask;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign run_step = req_chan.enable && enable_prev_ff && (wait_ff == '0);
   assign bit_step = phase_ff[0] && (phase_ff >= STEP_FIRST_BIT);
   // Bit position (step - 3) / 2 for odd steps
   assign pos_full = phase_ff[STEP_W-1:1] - (STEP_W-1)'(1);
   assign pos = pos_full[POS_W-1:0];
   assign bit_mask = BUTTON_BITS'(1) << pos;

   // Next state for one tick
   always_comb begin
      phase_in = phase_ff;
      wait_in = wait_ff;
      shift_p1_in = shift_p1_ff;
      shift_p2_in = shift_p2_ff;
      prev_p1_in = prev_p1_ff;
      prev_p2_in = prev_p2_ff;
      held_p1_in = held_p1_ff;
      held_p2_in = held_p2_ff;
      press_p1_scan = press_p1_ff;
      press_p2_scan = press_p2_ff;
      ready_flag_in = ready_flag_ff;

      if (req_chan.enable && !enable_prev_ff) begin
         wait_in = cfg.read_gap;
      end else if (run_step) begin
         if (phase_ff == '0) begin
            shift_p1_in = '0;
            shift_p2_in = '0;
         end else if (bit_step) begin
            shift_p1_in = shift_p1_ff | (req_chan.bit_p1 ? bit_mask : '0);
            shift_p2_in = shift_p2_ff | (req_chan.bit_p2 ? bit_mask : '0);
         end
         // Scan complete: publish words and collect new presses
         if (phase_ff == STEP_LAST) begin
            held_p1_in = shift_p1_in;
            held_p2_in = shift_p2_in;
            ready_flag_in = 1'b1;
            press_p1_scan = press_p1_ff | (shift_p1_in & ~prev_p1_ff);
            press_p2_scan = press_p2_ff | (shift_p2_in & ~prev_p2_ff);
            prev_p1_in = shift_p1_in;
            prev_p2_in = shift_p2_in;
            phase_in = '0;
         end else begin
            phase_in = phase_ff + STEP_W'(1);
         end
         wait_in = (phase_in == '0) ? cfg.read_gap : cfg.clock_half;
      end else if (req_chan.enable) begin
         wait_in = wait_ff - CFG_W'(1);
      end

      // Clears act after this item's result
      press_p1_in = req_chan.clear_p1 ? '0 : press_p1_scan;
      press_p2_in = req_chan.clear_p2 ? '0 : press_p2_scan;

      latch_in = (phase_in == STEP_LATCH_OFF);
      clock_in = phase_in[0] && (phase_in >= STEP_FIRST_BIT);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         wait_ff <= '0;
         shift_p1_ff <= '0;
         shift_p2_ff <= '0;
         prev_p1_ff <= '0;
         prev_p2_ff <= '0;
         held_p1_ff <= '0;
         held_p2_ff <= '0;
         press_p1_ff <= '0;
         press_p2_ff <= '0;
         ready_flag_ff <= 1'b0;
         enable_prev_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wait_ff <= wait_in;
         shift_p1_ff <= shift_p1_in;
         shift_p2_ff <= shift_p2_in;
         prev_p1_ff <= prev_p1_in;
         prev_p2_ff <= prev_p2_in;
         held_p1_ff <= held_p1_in;
         held_p2_ff <= held_p2_in;
         press_p1_ff <= press_p1_in;
         press_p2_ff <= press_p2_in;
         ready_flag_ff <= ready_flag_in;
         enable_prev_ff <= req_chan.enable;
      end
   end

   // Result register: loads on accept, drains on rsp handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         latch_ff <= latch_in;
         clock_ff <= clock_in;
         held_p1_out_ff <= WORD_W'(held_p1_in);
         held_p2_out_ff <= WORD_W'(held_p2_in);
         press_p1_out_ff <= WORD_W'(press_p1_scan);
         press_p2_out_ff <= WORD_W'(press_p2_scan);
         scan_ready_out_ff <= ready_flag_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.latch_strobe = latch_ff;
   assign rsp_chan.clock_strobe = clock_ff;
   assign rsp_chan.held_p1 = held_p1_out_ff;
   assign rsp_chan.held_p2 = held_p2_out_ff;
   assign rsp_chan.presses_p1 = press_p1_out_ff;
   assign rsp_chan.presses_p2 = press_p2_out_ff;
   assign rsp_chan.scan_ready = scan_ready_out_ff;

   // Checks
   `DSGR_ASSERT(a_phase_range, phase_ff <= STEP_LAST)
   `DSGR_ASSERT_NEXT(a_idle_holds_phase, accept && !req_chan.enable, $stable(phase_ff))
   `DSGR_ASSERT_NEXT(a_ready_sticky, ready_flag_ff, ready_flag_ff)
   `DSGR_ASSERT_NEXT(a_clear_p1, accept && req_chan.clear_p1, press_p1_ff == '0)
   `DSGR_ASSERT_NEXT(a_stall_holds_result, rsp_valid_ff && !rsp_chan.ready,
                     rsp_valid_ff && $stable(press_p1_out_ff))

endmodule
